### hdl/nns_pkg.sv
// nns_pkg: shared types, widths and defaults for the nearest-neighbor scaler
// used by nearest_neighbor_scaler; no dependencies
package nns_pkg;

   localparam int PIX_W         = 24;
   localparam int SRC_DIM_W     = 9;
   localparam int DST_DIM_W     = 13;
   localparam int FRAC_BITS     = 16;
   localparam int STEP_W        = SRC_DIM_W + FRAC_BITS;
   localparam int CNT_W         = DST_DIM_W;
   localparam int ACC_W         = CNT_W + STEP_W;
   localparam int FRAME_W       = 2 * SRC_DIM_W;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = DST_DIM_W;
   localparam int DIV_CNT_W     = $clog2(STEP_W + 1);

   localparam int DEF_MAX_SRC_WIDTH  = 256;
   localparam int DEF_MAX_SRC_HEIGHT = 256;
   localparam int DEF_MAX_DST_DIM    = 4096;

   localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 9'd256;
   localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 9'd256;
   localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 13'd1024;
   localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 13'd768;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_OUTPUT = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DIVIDE,
      ST_IDLE,
      ST_ADDR,
      ST_READ
   } state_type;

endpackage

### hdl/nns_ram.sv
// nns_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module nns_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nearest_neighbor_scaler.sv
// nearest_neighbor_scaler: nearest-neighbor rgb scaler with 9.16 fixed-point steps
// depends on nns_pkg and nns_ram
//
// usage:
//   req channel: tuser[0] is the request kind (0 load, 1 output), tdata[23:0] the
//   source pixel. loads fill the frame store in raster order and wrap at
//   source width * source height; the first wrap marks the frame as loaded.
//   rsp channel: tdata[23:0] the scaled pixel, tlast set on the last pixel of the
//   destination frame. one word per output request once a frame is loaded; an
//   output request before that is taken and dropped.
//   csr port: writes the four dimension registers; any write restarts load and
//   output counters and clears the loaded flag. write only while idle.
// timing:
//   a load is written to the frame store as it is taken. an output request
//   passes the steps step, address and frame store read; the coordinate
//   register and the registered store read lie between request and result.
//   the result waits in an output register, so req stays open while rsp is
//   stalled; a following output request stalls in the read stage, with
//   req_tready low, only while that register is still full. after reset and
//   after each csr write the two step dividers run with req_tready low.
module nearest_neighbor_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nns_pkg::PIX_W-1:0]        req_tdata,   // pixel_in
   input  logic [0:0]                       req_tuser,   // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nns_pkg::PIX_W-1:0]        rsp_tdata,   // pixel_out
   output logic                             rsp_tlast,   // end_of_frame
   input  logic                             csr_we,
   input  logic [nns_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [nns_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import nns_pkg::*;

   localparam int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH;
   localparam int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT;
   localparam int MAX_DST_DIM    = DEF_MAX_DST_DIM;
   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = (ADDR_W > FRAME_W) ? ADDR_W : FRAME_W;
   localparam int CMP_W  = IDX_W + 1;
   localparam int SRCX_W = ACC_W - FRAC_BITS;

   // registers
   logic [SRC_DIM_W-1:0] src_cols_ff, src_rows_ff;
   logic [DST_DIM_W-1:0] dst_width_ff, dst_height_ff;
   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [STEP_W-1:0]    col_num_ff, col_num_in, row_num_ff, row_num_in;
   logic [DST_DIM_W-1:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic                 loaded_ff, loaded_in;
   logic [ADDR_W-1:0]    load_ptr_ff, load_ptr_in;
   logic [CNT_W-1:0]     out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [ACC_W-1:0]     col_acc_ff, col_acc_in, row_acc_ff, row_acc_in;
   logic [SRC_DIM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]     rsp_pixel_ff, rsp_pixel_in;
   logic                 rsp_last_ff, rsp_last_in;

   // combinational
   logic [SRC_DIM_W-1:0] sw, sh;
   logic [DST_DIM_W-1:0] dw, dh;
   logic [FRAME_W-1:0]   frame_size;
   logic                 req_fire, load_fire, out_fire;
   logic                 rsp_load, ram_rd_en;
   logic [DST_DIM_W:0]   col_rem_sh, row_rem_sh;
   logic [SRCX_W-1:0]    col_src, row_src;
   logic [CMP_W-1:0]     ptr_inc;
   logic [IDX_W-1:0]     idx;
   logic [ADDR_W-1:0]    rd_addr;
   logic [PIX_W-1:0]     rd_data;
   logic                 col_end, row_end;

   // clamped dimensions
   always_comb begin
      if (src_cols_ff == '0) sw = SRC_DIM_W'(1);
      else if (32'(src_cols_ff) > 32'(MAX_SRC_WIDTH)) sw = SRC_DIM_W'(MAX_SRC_WIDTH);
      else sw = src_cols_ff;
      if (src_rows_ff == '0) sh = SRC_DIM_W'(1);
      else if (32'(src_rows_ff) > 32'(MAX_SRC_HEIGHT)) sh = SRC_DIM_W'(MAX_SRC_HEIGHT);
      else sh = src_rows_ff;
      if (dst_width_ff == '0) dw = DST_DIM_W'(1);
      else if (32'(dst_width_ff) > 32'(MAX_DST_DIM)) dw = DST_DIM_W'(MAX_DST_DIM);
      else dw = dst_width_ff;
      if (dst_height_ff == '0) dh = DST_DIM_W'(1);
      else if (32'(dst_height_ff) > 32'(MAX_DST_DIM)) dh = DST_DIM_W'(MAX_DST_DIM);
      else dh = dst_height_ff;
   end

   assign frame_size = FRAME_W'(sw) * FRAME_W'(sh);

   assign req_fire  = req_tvalid && req_tready;
   assign load_fire = req_fire && (req_tuser[0] == REQ_LOAD);
   assign out_fire  = req_fire && (req_tuser[0] == REQ_OUTPUT) && loaded_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_DIVIDE: begin
            if (div_cnt_ff == DIV_CNT_W'(STEP_W)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (out_fire) state_in = ST_ADDR;
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_DIVIDE;
         end
      endcase
      if (csr_we) state_in = ST_DIVIDE;
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_DIVIDE: begin
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_ADDR: begin
            ram_rd_en = 1'b1;
         end
         ST_READ: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // step dividers: restoring, one quotient bit per cycle
   always_comb begin
      div_cnt_in = div_cnt_ff;
      col_num_in = col_num_ff;
      row_num_in = row_num_ff;
      col_rem_in = col_rem_ff;
      row_rem_in = row_rem_ff;
      col_rem_sh = {col_rem_ff, col_num_ff[STEP_W-1]};
      row_rem_sh = {row_rem_ff, row_num_ff[STEP_W-1]};
      if (state_ff == ST_DIVIDE) begin
         if (div_cnt_ff == '0) begin
            col_num_in = {sw, FRAC_BITS'(0)};
            row_num_in = {sh, FRAC_BITS'(0)};
            col_rem_in = '0;
            row_rem_in = '0;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end else if (div_cnt_ff != DIV_CNT_W'(STEP_W)) begin
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         end
         if (div_cnt_ff != '0) begin
            if (col_rem_sh >= {1'b0, dw}) begin
               col_rem_in = DST_DIM_W'(col_rem_sh - {1'b0, dw});
               col_num_in = {col_num_ff[STEP_W-2:0], 1'b1};
            end else begin
               col_rem_in = col_rem_sh[DST_DIM_W-1:0];
               col_num_in = {col_num_ff[STEP_W-2:0], 1'b0};
            end
            if (row_rem_sh >= {1'b0, dh}) begin
               row_rem_in = DST_DIM_W'(row_rem_sh - {1'b0, dh});
               row_num_in = {row_num_ff[STEP_W-2:0], 1'b1};
            end else begin
               row_rem_in = row_rem_sh[DST_DIM_W-1:0];
               row_num_in = {row_num_ff[STEP_W-2:0], 1'b0};
            end
         end
      end
      if (csr_we) div_cnt_in = '0;
   end

   // load pointer and loaded flag
   assign ptr_inc = CMP_W'(load_ptr_ff) + CMP_W'(1);

   always_comb begin
      load_ptr_in = load_ptr_ff;
      loaded_in   = loaded_ff;
      if (load_fire) begin
         if (ptr_inc >= CMP_W'(frame_size)) begin
            load_ptr_in = '0;
            loaded_in   = 1'b1;
         end else begin
            load_ptr_in = ptr_inc[ADDR_W-1:0];
         end
      end
      if (csr_we) begin
         load_ptr_in = '0;
         loaded_in   = 1'b0;
      end
   end

   // destination walk; accumulators hold out_col * col_step and out_row * row_step
   assign col_src = col_acc_ff[ACC_W-1:FRAC_BITS];
   assign row_src = row_acc_ff[ACC_W-1:FRAC_BITS];
   assign col_end = (out_col_ff == CNT_W'(dw - DST_DIM_W'(1)));
   assign row_end = (out_row_ff == CNT_W'(dh - DST_DIM_W'(1)));

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      col_acc_in = col_acc_ff;
      row_acc_in = row_acc_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      last_in    = last_ff;
      if (out_fire) begin
         sx_in   = (col_src >= SRCX_W'(sw)) ? sw - SRC_DIM_W'(1) : col_src[SRC_DIM_W-1:0];
         sy_in   = (row_src >= SRCX_W'(sh)) ? sh - SRC_DIM_W'(1) : row_src[SRC_DIM_W-1:0];
         last_in = col_end && row_end;
         if (col_end) begin
            out_col_in = '0;
            col_acc_in = '0;
            if (row_end) begin
               out_row_in = '0;
               row_acc_in = '0;
            end else begin
               out_row_in = out_row_ff + CNT_W'(1);
               row_acc_in = row_acc_ff + ACC_W'(row_num_ff);
            end
         end else begin
            out_col_in = out_col_ff + CNT_W'(1);
            col_acc_in = col_acc_ff + ACC_W'(col_num_ff);
         end
      end
      if (csr_we) begin
         out_col_in = '0;
         out_row_in = '0;
         col_acc_in = '0;
         row_acc_in = '0;
      end
   end

   // store address
   always_comb begin
      idx = IDX_W'(sy_ff) * IDX_W'(sw) + IDX_W'(sx_ff);
      if (32'(idx) >= 32'(DEPTH)) rd_addr = ADDR_W'(DEPTH - 1);
      else rd_addr = idx[ADDR_W-1:0];
   end

   nns_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (load_ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = rd_data;
         rsp_last_in  = last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_cols_ff   <= RST_SRC_WIDTH;
         src_rows_ff   <= RST_SRC_HEIGHT;
         dst_width_ff  <= RST_DST_WIDTH;
         dst_height_ff <= RST_DST_HEIGHT;
         state_ff      <= ST_DIVIDE;
         div_cnt_ff    <= '0;
         loaded_ff     <= 1'b0;
         load_ptr_ff   <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         col_acc_ff    <= '0;
         row_acc_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SRC_WIDTH:  src_cols_ff   <= csr_wdata[SRC_DIM_W-1:0];
               CSR_SRC_HEIGHT: src_rows_ff   <= csr_wdata[SRC_DIM_W-1:0];
               CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[DST_DIM_W-1:0];
               CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[DST_DIM_W-1:0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         loaded_ff    <= loaded_in;
         load_ptr_ff  <= load_ptr_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      col_num_ff   <= col_num_in;
      row_num_ff   <= row_num_in;
      col_rem_ff   <= col_rem_in;
      row_rem_ff   <= row_rem_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      last_ff      <= last_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
